// ===== hdl/frame_chunk_reassembly_tracker_assert.svh =====
// assertion helpers for the frame chunk reassembly tracker
`ifndef FRAME_CHUNK_REASSEMBLY_TRACKER_ASSERT_SVH
`define FRAME_CHUNK_REASSEMBLY_TRACKER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define FCRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FCRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fcrt_pkg.sv =====
// ----------------------------------------------------------------------------
// fcrt_pkg
// Shared types, widths and codes of the frame chunk reassembly tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package fcrt_pkg;

    // number of reassembly slots (1 to 4)
    localparam int SLOTS  = 4;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    localparam int TIME_W  = 48;
    localparam int COUNT_W = 16;
    localparam int BYTES_W = 32;
    localparam int OFFS_W  = 16;

    // result status codes
    localparam logic [2:0] ST_ACCEPT   = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_LATE     = 3'd2;
    localparam logic [2:0] ST_TOO_MANY = 3'd3;
    localparam logic [2:0] ST_NO_SLOT  = 3'd4;
    localparam logic [2:0] ST_INACTIVE = 3'd5;

    // chunk header transaction
    typedef struct packed {
        logic [TIME_W-1:0]        frame_time;
        logic signed [OFFS_W-1:0] sender_offset;
        logic [7:0]               blk_per_chan;
        logic [7:0]               num_chans;
        logic [15:0]              byte_count;
        logic [TIME_W-1:0]        arrival_time;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [2:0]               status;
        logic [1:0]               slot_index;
        logic                     evicted;
        logic [COUNT_W-1:0]       chunks_seen;
        logic [COUNT_W-1:0]       chunks_expected;
        logic [BYTES_W-1:0]       frame_bytes;
        logic signed [TIME_W-1:0] latency;
    } t_out_item;

    // one slot's bookkeeping fields
    typedef struct packed {
        logic [TIME_W-1:0]  frame_time;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] total;
        logic [BYTES_W-1:0] bytes;
        logic [OFFS_W-1:0]  first_off;
    } t_slot_entry;

    // slot file write request
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] idx;
        logic              valid;
        t_slot_entry       entry;
    } t_slot_wr;

    // shared unit operations
    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } t_alu_op;

endpackage

`default_nettype wire

// ===== hdl/frame_chunk_reassembly_tracker.sv =====
// ----------------------------------------------------------------------------
// frame_chunk_reassembly_tracker
// Tracks chunk arrival per frame over a small set of reassembly slots and
// reports per-chunk status, byte totals and completion latency.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_data) takes one chunk header
//   per transaction; output channel (o_out_valid/i_out_ready, o_out_data)
//   returns exactly one result per header, in order.
//   i_cfg_we/i_cfg_wdata write the enable bit; write it only while idle.
//   With enable low the header skips the slot steps and goes straight to the
//   emit step with an inactive status.
//   Otherwise a sequencer scans the slots one per cycle through one shared
//   48-bit add/compare unit, then runs allocate, age check and update steps;
//   a header with no slot skips two steps (age check and update), and a
//   completing frame adds the latency add and subtract steps on the same unit.
//   o_in_ready is high only while the sequencer is idle, so one header is in
//   work at a time. A finished result sits in the output register; the next
//   header is accepted while it waits, and a stalled receiver only holds the
//   sequencer once that header's result is ready too.
//   Reset clears the enable bit, slot valid bits, the last completed frame
//   time and the output valid, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_chunk_reassembly_tracker_assert.svh"

module frame_chunk_reassembly_tracker
    import fcrt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_LATE,
        S_UPD,
        S_LAT1,
        S_LAT2,
        S_EMIT
    } t_state;

    t_state            r_state,    n_state;
    t_in_item          r_item,     n_item;
    logic [SLOT_W-1:0] r_idx,      n_idx;
    logic              r_hit,      n_hit;
    logic [SLOT_W-1:0] r_hit_idx,  n_hit_idx;
    logic              r_free,     n_free;
    logic [SLOT_W-1:0] r_free_idx, n_free_idx;
    logic              r_old,      n_old;
    logic [SLOT_W-1:0] r_old_idx,  n_old_idx;
    logic [TIME_W-1:0] r_best,     n_best;
    logic [SLOT_W-1:0] r_sel,      n_sel;
    logic              r_ev,       n_ev;
    logic              r_late,     n_late;
    logic [TIME_W-1:0] r_lat_tmp,  n_lat_tmp;
    t_out_item         r_res,      n_res;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_data, n_out_data;
    logic              r_enable,   n_enable;
    logic [TIME_W-1:0] r_last_done, n_last_done;

    t_slot_wr          w_wr;
    logic [SLOT_W-1:0] w_rd_idx;
    t_slot_entry       w_rd;
    logic              w_rd_valid;

    t_alu_op           w_alu_op;
    logic [TIME_W-1:0] w_alu_a;
    logic [TIME_W-1:0] w_alu_b;
    logic [TIME_W-1:0] w_alu_res;
    logic              w_alu_lt;
    logic              w_alu_eq;

    logic [BYTES_W:0]   u_sum;
    logic [BYTES_W-1:0] u_bytes;
    logic [COUNT_W-1:0] u_total;
    logic [COUNT_W-1:0] u_next;
    logic               u_over;
    logic               u_complete;
    logic [OFFS_W-1:0]  u_off;

    logic w_in_acc;

    fcrt_slot_file u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .i_rd_idx   (w_rd_idx),
        .o_rd_entry (w_rd),
        .o_rd_valid (w_rd_valid)
    );

    fcrt_alu u_alu (
        .i_op  (w_alu_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu_res),
        .o_lt  (w_alu_lt),
        .o_eq  (w_alu_eq)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // slot update datapath, read from the selected slot
    always_comb begin
        u_sum      = {1'b0, w_rd.bytes} + {{(BYTES_W - 16 + 1){1'b0}}, r_item.byte_count};
        u_bytes    = u_sum[BYTES_W] ? '1 : u_sum[BYTES_W-1:0];
        u_total    = (w_rd.total == '0)
                   ? ({8'b0, r_item.blk_per_chan} * {8'b0, r_item.num_chans})
                   : w_rd.total;
        u_next     = w_rd.count + COUNT_W'(1);
        u_over     = (u_next == '0) || (u_next > u_total);
        u_complete = !u_over && (u_next == u_total);
        u_off      = (u_next == COUNT_W'(1)) ? r_item.sender_offset : w_rd.first_off;
    end

    // sequencer next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_old       = r_old;
        n_old_idx   = r_old_idx;
        n_best      = r_best;
        n_sel       = r_sel;
        n_ev        = r_ev;
        n_late      = r_late;
        n_lat_tmp   = r_lat_tmp;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_enable    = i_cfg_we ? i_cfg_wdata : r_enable;
        n_last_done = r_last_done;

        w_wr      = '0;
        w_rd_idx  = r_idx;
        w_alu_op  = ALU_SUB;
        w_alu_a   = w_rd.frame_time;
        w_alu_b   = r_best;

        // output register drains on a completed transaction
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_item = i_in_data;
                    n_idx  = '0;
                    n_hit  = 1'b0;
                    n_free = 1'b0;
                    n_old  = 1'b0;
                    n_ev   = 1'b0;
                    n_best = i_in_data.frame_time;
                    n_res  = '0;
                    if (!r_enable) begin
                        n_res.status = ST_INACTIVE;
                        n_state      = S_EMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            // one slot per cycle: match, first free, oldest older frame
            S_SCAN: begin
                if (w_rd_valid && (w_rd.frame_time == r_item.frame_time) && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                end
                if (!w_rd_valid && !r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_idx;
                end
                if (w_rd_valid && w_alu_lt) begin
                    n_old     = 1'b1;
                    n_old_idx = r_idx;
                    n_best    = w_rd.frame_time;
                end
                if (r_idx == SLOT_LAST) begin
                    n_state = S_ALLOC;
                end else begin
                    n_idx = SLOT_W'(r_idx + 1'b1);
                end
            end

            // pick the slot, taking a fresh one when needed
            S_ALLOC: begin
                w_wr.valid                = 1'b1;
                w_wr.entry                = '0;
                w_wr.entry.frame_time     = r_item.frame_time;
                priority if (r_hit) begin
                    n_sel   = r_hit_idx;
                    n_state = S_LATE;
                end else if (r_free) begin
                    w_wr.we  = 1'b1;
                    w_wr.idx = r_free_idx;
                    n_sel    = r_free_idx;
                    n_state  = S_LATE;
                end else if (r_old) begin
                    w_wr.we  = 1'b1;
                    w_wr.idx = r_old_idx;
                    n_sel    = r_old_idx;
                    n_ev     = 1'b1;
                    n_state  = S_LATE;
                end else begin
                    n_res.status = ST_NO_SLOT;
                    n_state      = S_EMIT;
                end
            end

            // frame not newer than the last completed one
            S_LATE: begin
                w_rd_idx = r_sel;
                w_alu_a  = r_item.frame_time;
                w_alu_b  = r_last_done;
                n_late   = (r_last_done != '0) && (w_alu_lt || w_alu_eq);
                n_state  = S_UPD;
            end

            // count, total, bytes and completion
            S_UPD: begin
                w_rd_idx                 = r_sel;
                w_wr.we                  = 1'b1;
                w_wr.idx                 = r_sel;
                w_wr.valid               = 1'b1;
                w_wr.entry               = w_rd;
                w_wr.entry.bytes         = u_bytes;
                n_res.slot_index         = 2'(r_sel);
                n_res.evicted            = r_ev;
                n_res.frame_bytes        = u_bytes;
                n_state                  = S_EMIT;
                priority if (r_late) begin
                    n_res.status          = ST_LATE;
                    n_res.chunks_seen     = w_rd.count;
                    n_res.chunks_expected = w_rd.total;
                end else if (u_over) begin
                    w_wr.entry.total      = u_total;
                    n_res.status          = ST_TOO_MANY;
                    n_res.chunks_seen     = w_rd.count;
                    n_res.chunks_expected = u_total;
                end else begin
                    w_wr.entry.total      = u_total;
                    w_wr.entry.count      = u_next;
                    w_wr.entry.first_off  = u_off;
                    n_res.chunks_seen     = u_next;
                    n_res.chunks_expected = u_total;
                    if (u_complete) begin
                        w_wr.valid   = 1'b0;
                        n_last_done  = r_item.frame_time;
                        n_res.status = ST_COMPLETE;
                        n_state      = S_LAT1;
                    end else begin
                        n_res.status = ST_ACCEPT;
                    end
                end
            end

            // frame time plus first offset
            S_LAT1: begin
                w_rd_idx  = r_sel;
                w_alu_op  = ALU_ADD;
                w_alu_a   = r_item.frame_time;
                w_alu_b   = {{(TIME_W - OFFS_W){w_rd.first_off[OFFS_W-1]}}, w_rd.first_off};
                n_lat_tmp = w_alu_res;
                n_state   = S_LAT2;
            end

            // arrival minus that sum
            S_LAT2: begin
                w_alu_a       = r_item.arrival_time;
                w_alu_b       = r_lat_tmp;
                n_res.latency = $signed(w_alu_res);
                n_state       = S_EMIT;
            end

            // hand the result to the output register when it is free
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b0;
            r_last_done <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_enable    <= n_enable;
            r_last_done <= n_last_done;
        end
        r_item     <= n_item;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_old      <= n_old;
        r_old_idx  <= n_old_idx;
        r_best     <= n_best;
        r_sel      <= n_sel;
        r_ev       <= n_ev;
        r_late     <= n_late;
        r_lat_tmp  <= n_lat_tmp;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    // checks
    `FCRT_ASSERT_IMP(a_scan_full, i_clk, i_rst_n, r_state == S_ALLOC, r_idx == SLOT_LAST, "slot scan ended early")
    `FCRT_ASSERT_IMP(a_evict_last, i_clk, i_rst_n, (r_state == S_LATE) && r_ev, !r_hit && !r_free, "eviction with a matching or free slot")
    `FCRT_ASSERT_IMP(a_lat_done_only, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_COMPLETE), o_out_data.latency == '0, "latency reported without completion")
    `FCRT_ASSERT_IMP(a_done_time_src, i_clk, i_rst_n, $past(i_rst_n) && (r_last_done != $past(r_last_done)), $past(r_state == S_UPD), "last completed time changed outside update")
    `FCRT_ASSERT_NXT(a_one_in_work, i_clk, i_rst_n, w_in_acc, !o_in_ready, "new header taken while one is in work")

endmodule

`default_nettype wire

// ===== hdl/fcrt_alu.sv =====
// ----------------------------------------------------------------------------
// fcrt_alu
// Shared 48-bit add/subtract unit with unsigned less-than and equal flags.
// ----------------------------------------------------------------------------
`default_nettype none

module fcrt_alu
    import fcrt_pkg::*;
(
    input  t_alu_op           i_op,
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    output logic [TIME_W-1:0] o_res,
    output logic              o_lt,
    output logic              o_eq
);

    logic [TIME_W:0] w_diff;

    // borrow of the difference gives a < b
    assign w_diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_lt   = w_diff[TIME_W];
    assign o_eq   = (i_a == i_b);

    // result select
    always_comb begin
        unique case (i_op)
            ALU_ADD: o_res = i_a + i_b;
            ALU_SUB: o_res = w_diff[TIME_W-1:0];
            default: o_res = w_diff[TIME_W-1:0];
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/fcrt_slot_file.sv =====
// ----------------------------------------------------------------------------
// fcrt_slot_file
// Reassembly slot registers: valid bits cleared at reset, one write port and
// one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fcrt_slot_file
    import fcrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_slot_wr          i_wr,
    input  logic [SLOT_W-1:0] i_rd_idx,
    output t_slot_entry       o_rd_entry,
    output logic              o_rd_valid
);

    logic [SLOTS-1:0] r_valid;
    t_slot_entry      r_entry [SLOTS];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.idx] <= i_wr.valid;
        end
    end

    // slot fields, written before any read
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_entry[i_wr.idx] <= i_wr.entry;
        end
    end

    // read port
    assign o_rd_entry = r_entry[i_rd_idx];
    assign o_rd_valid = r_valid[i_rd_idx];

endmodule

`default_nettype wire

// ===== bench/tb_frame_chunk_reassembly_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_frame_chunk_reassembly_tracker
// Self-checking bench for the frame chunk reassembly tracker. A short table of
// directed chunk headers covers the corner cases (inactive source, frame time
// zero, late and duplicate frames, zero chunk totals, no free slot, eviction).
// Random bursts of interleaved frames with late and junk headers mixed in
// follow. Every result is compared field by field against a fixed row result
// or an in-bench slot table model, under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_frame_chunk_reassembly_tracker;
    import fcrt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 20;
    localparam int ITEMS_PER_MIX  = 120;
    localparam int NUM_MIXES      = 5;

    // sender idle and receiver stall percentages, one pair per mix
    localparam int SND_IDLE  [NUM_MIXES] = '{0, 84, 0, 19, 0};
    localparam int RCV_STALL [NUM_MIXES] = '{0, 0, 84, 19, 0};

    typedef enum logic {
        ROW_CHUNK,
        ROW_ENABLE
    } t_row_kind;

    // one directed row: a header or an enable write, with an optional fixed result
    typedef struct packed {
        t_row_kind kind;
        logic      enable_val;
        t_in_item  chunk;
        logic      fixed;
        t_out_item want;
    } t_dir_row;

    localparam t_in_item  NO_CHUNK     = '0;
    localparam t_out_item NO_RESULT    = '0;
    localparam t_out_item RES_INACTIVE =
        '{ST_INACTIVE, 2'd0, 1'b0, 16'd0, 16'd0, 32'd0, 48'sd0};
    localparam t_out_item RES_NO_SLOT  =
        '{ST_NO_SLOT, 2'd0, 1'b0, 16'd0, 16'd0, 32'd0, 48'sd0};

    localparam int DIR_N = 21;
    localparam t_dir_row DIRECTED [DIR_N] = '{
        // source inactive, field extremes
        '{ROW_CHUNK, 1'b0, '{48'hFFFF_FFFF_FFFF, 16'sh8000, 8'd255, 8'd255, 16'hFFFF,
            48'hFFFF_FFFF_FFFF}, 1'b1, RES_INACTIVE},
        '{ROW_CHUNK, 1'b0, '{48'd0, 16'sh7FFF, 8'd1, 8'd1, 16'd0, 48'd0},
            1'b1, RES_INACTIVE},
        '{ROW_ENABLE, 1'b1, NO_CHUNK, 1'b0, NO_RESULT},
        // frame time zero completes twice, since zero means none completed
        '{ROW_CHUNK, 1'b0, '{48'd0, 16'sh7FFF, 8'd1, 8'd1, 16'd0, 48'h1_0000}, 1'b1,
            '{ST_COMPLETE, 2'd0, 1'b0, 16'd1, 16'd1, 32'd0, 48'sh8001}},
        '{ROW_CHUNK, 1'b0, '{48'd0, 16'sh8000, 8'd1, 8'd1, 16'hFFFF, 48'd0}, 1'b1,
            '{ST_COMPLETE, 2'd0, 1'b0, 16'd1, 16'd1, 32'd65535, 48'sh8000}},
        // two-chunk frame, negative first offset
        '{ROW_CHUNK, 1'b0, '{48'd100, -16'sd5, 8'd1, 8'd2, 16'hFFFF, 48'd200}, 1'b1,
            '{ST_ACCEPT, 2'd0, 1'b0, 16'd1, 16'd2, 32'd65535, 48'sd0}},
        '{ROW_CHUNK, 1'b0, '{48'd100, 16'sd7, 8'd1, 8'd2, 16'd1, 48'd300}, 1'b1,
            '{ST_COMPLETE, 2'd0, 1'b0, 16'd2, 16'd2, 32'd65536, 48'sd205}},
        // duplicate and older frames are late but keep their slot
        '{ROW_CHUNK, 1'b0, '{48'd100, 16'sd0, 8'd1, 8'd1, 16'd10, 48'd0}, 1'b1,
            '{ST_LATE, 2'd0, 1'b0, 16'd0, 16'd0, 32'd10, 48'sd0}},
        '{ROW_CHUNK, 1'b0, '{48'd40, 16'sd0, 8'd1, 8'd1, 16'd3, 48'd0}, 1'b1,
            '{ST_LATE, 2'd1, 1'b0, 16'd0, 16'd0, 32'd3, 48'sd0}},
        // zero chunk total gives too many, then the total is set later
        '{ROW_CHUNK, 1'b0, '{48'd500, 16'sd0, 8'd0, 8'd7, 16'd20, 48'd0}, 1'b1,
            '{ST_TOO_MANY, 2'd2, 1'b0, 16'd0, 16'd0, 32'd20, 48'sd0}},
        '{ROW_CHUNK, 1'b0, '{48'd500, 16'sd0, 8'd3, 8'd0, 16'd20, 48'd0},
            1'b0, NO_RESULT},
        '{ROW_CHUNK, 1'b0, '{48'd500, 16'sh1234, 8'd2, 8'd3, 16'd5, 48'd1000},
            1'b0, NO_RESULT},
        '{ROW_CHUNK, 1'b0, '{48'd600, -16'sd100, 8'd255, 8'd255, 16'd9, 48'd1000},
            1'b0, NO_RESULT},
        // all slots busy and the frame is the oldest
        '{ROW_CHUNK, 1'b0, '{48'd30, 16'sd0, 8'd1, 8'd1, 16'd1, 48'd0}, 1'b1, RES_NO_SLOT},
        '{ROW_CHUNK, 1'b0, '{48'd40, 16'sd0, 8'd1, 8'd1, 16'd2, 48'd0}, 1'b0, NO_RESULT},
        // newer frame evicts the oldest slot
        '{ROW_CHUNK, 1'b0, '{48'd700, 16'sd3, 8'd1, 8'd1, 16'd77, 48'd5000},
            1'b0, NO_RESULT},
        '{ROW_CHUNK, 1'b0, '{48'd500, 16'sd0, 8'd2, 8'd3, 16'd1, 48'd0}, 1'b0, NO_RESULT},
        '{ROW_CHUNK, 1'b0, '{48'd800, 16'sd0, 8'd1, 8'd2, 16'd1, 48'd900}, 1'b0, NO_RESULT},
        '{ROW_CHUNK, 1'b0, '{48'd900, 16'sd0, 8'd1, 8'd2, 16'd1, 48'd950}, 1'b0, NO_RESULT},
        '{ROW_CHUNK, 1'b0, '{48'd900, 16'sd0, 8'd1, 8'd2, 16'd1, 48'd990}, 1'b0, NO_RESULT},
        '{ROW_CHUNK, 1'b0, '{48'd800, 16'sd0, 8'd1, 8'd2, 16'd1, 48'd999}, 1'b0, NO_RESULT}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    // slot table model
    logic                src_enable;
    logic                slot_busy  [SLOTS];
    logic [TIME_W-1:0]   slot_frame [SLOTS];
    logic [COUNT_W-1:0]  slot_seen  [SLOTS];
    logic [COUNT_W-1:0]  slot_need  [SLOTS];
    logic [BYTES_W-1:0]  slot_bytes [SLOTS];
    logic [OFFS_W-1:0]   slot_off   [SLOTS];
    logic [TIME_W-1:0]   done_time;

    t_out_item pending_results [$];

    int          snd_idle        = 0;
    int          rcv_stall       = 0;
    int          mismatches      = 0;
    int          results_checked = 0;
    int          evictions       = 0;
    int          live_items      = 0;
    int          off_items       = 0;
    int          status_tally [8];
    int          stall_cycles    = 0;
    logic [47:0] frame_clock;

    frame_chunk_reassembly_tracker u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    // receiver back-pressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= rcv_stall);
    end

    // claim a slot for a new frame time
    function automatic void open_slot(int idx, logic [TIME_W-1:0] t);
        slot_busy[idx]  = 1'b1;
        slot_frame[idx] = t;
        slot_seen[idx]  = '0;
        slot_need[idx]  = '0;
        slot_bytes[idx] = '0;
        slot_off[idx]   = '0;
    endfunction

    // slot lookup, byte count and completion for one chunk header
    function automatic t_out_item track_chunk(t_in_item c);
        t_out_item          r;
        logic               found;
        int                 s;
        logic [TIME_W-1:0]  oldest;
        logic [32:0]        sum;
        logic [COUNT_W-1:0] next_seen;
        logic [COUNT_W-1:0] product;
        logic [TIME_W-1:0]  off_ext;
        r     = '0;
        found = 1'b0;
        s     = 0;
        if (!src_enable) begin
            r.status = ST_INACTIVE;
            return r;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_busy[i] && slot_frame[i] == c.frame_time) begin
                s     = i;
                found = 1'b1;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!found && !slot_busy[i]) begin
                s     = i;
                found = 1'b1;
                open_slot(s, c.frame_time);
            end
        end
        // no free slot: evict the first oldest, unless this frame is the oldest
        if (!found) begin
            oldest = c.frame_time;
            for (int i = 0; i < SLOTS; i++)
                if (slot_frame[i] < oldest) oldest = slot_frame[i];
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && oldest != c.frame_time && slot_frame[i] == oldest) begin
                    s           = i;
                    found       = 1'b1;
                    r.evicted   = 1'b1;
                    open_slot(s, c.frame_time);
                end
            end
        end
        if (!found) begin
            r.status = ST_NO_SLOT;
            return r;
        end
        sum           = {1'b0, slot_bytes[s]} + c.byte_count;
        slot_bytes[s] = sum[32] ? '1 : sum[31:0];
        if (done_time != 0 && slot_frame[s] <= done_time) begin
            r.status = ST_LATE;
        end else begin
            product = c.blk_per_chan * c.num_chans;
            if (slot_need[s] == 0) slot_need[s] = product;
            next_seen = slot_seen[s] + 1'b1;
            if (next_seen > slot_need[s] || next_seen == 0) begin
                r.status = ST_TOO_MANY;
            end else begin
                slot_seen[s] = next_seen;
                if (next_seen == 1) slot_off[s] = c.sender_offset;
                r.status = ST_ACCEPT;
                if (next_seen == slot_need[s]) begin
                    off_ext      = {{(TIME_W - OFFS_W){slot_off[s][OFFS_W-1]}}, slot_off[s]};
                    done_time    = slot_frame[s];
                    r.latency    = c.arrival_time - (slot_frame[s] + off_ext);
                    slot_busy[s] = 1'b0;
                    r.status     = ST_COMPLETE;
                end
            end
        end
        r.slot_index      = 2'(s);
        r.chunks_seen     = slot_seen[s];
        r.chunks_expected = slot_need[s];
        r.frame_bytes     = slot_bytes[s];
        return r;
    endfunction

    // header with every field random
    function automatic t_in_item noise_chunk();
        t_in_item c;
        c.frame_time    = 48'({$urandom(), $urandom()});
        c.sender_offset = 16'($urandom());
        c.blk_per_chan  = 8'($urandom());
        c.num_chans     = 8'($urandom());
        c.byte_count    = 16'($urandom());
        c.arrival_time  = 48'({$urandom(), $urandom()});
        return c;
    endfunction

    // present one header, wait for the transaction, queue its result
    task automatic send_chunk(input t_in_item c, input logic fixed, input t_out_item fixed_res);
        t_out_item predicted;
        while ($urandom_range(0, 99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do @(posedge clk); while (in_ready !== 1'b1);
        predicted = track_chunk(c);
        pending_results.push_back(fixed ? fixed_res : predicted);
    endtask

    // hold the sender until every queued result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic set_enable(input logic val);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we     <= 1'b0;
        src_enable  = val;
    endtask

    // a few frames, most sent to completion, interleaved, with late and junk headers
    task automatic send_burst();
        t_in_item fr [5];
        int       left [5];
        int       nf;
        int       f;
        int       remain;
        t_in_item c;
        nf     = $urandom_range(1, 5);
        remain = 0;
        for (int k = 0; k < nf; k++) begin
            frame_clock += 48'($urandom_range(1, 1000));
            fr[k] = noise_chunk();
            fr[k].frame_time = frame_clock;
            if ($urandom_range(0, 7) == 0) begin
                // big frame left open, to be evicted later
                fr[k].blk_per_chan = 8'($urandom_range(1, 255));
                fr[k].num_chans    = 8'($urandom_range(1, 255));
                left[k] = $urandom_range(1, 6);
            end else begin
                fr[k].blk_per_chan = 8'($urandom_range(1, 4));
                fr[k].num_chans    = 8'($urandom_range(1, 3));
                left[k] = int'(fr[k].blk_per_chan) * int'(fr[k].num_chans);
            end
            remain += left[k];
        end
        while (remain > 0) begin
            f = $urandom_range(0, nf - 1);
            if (left[f] == 0) continue;
            if ($urandom_range(0, 7) == 0) begin
                c = noise_chunk();
                if ($urandom_range(0, 1) == 1) c.frame_time = done_time;
                send_chunk(c, 1'b0, NO_RESULT);
                live_items++;
            end
            c = noise_chunk();
            c.frame_time   = fr[f].frame_time;
            c.blk_per_chan = fr[f].blk_per_chan;
            c.num_chans    = fr[f].num_chans;
            send_chunk(c, 1'b0, NO_RESULT);
            live_items++;
            left[f]--;
            remain--;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result checking against the oldest queued expectation
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            status_tally[out_data.status]++;
            if (out_data.evicted) evictions++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, out_data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, out_data.status);
                check_field("slot_index", want.slot_index, out_data.slot_index);
                check_field("evicted", want.evicted, out_data.evicted);
                check_field("chunks_seen", want.chunks_seen, out_data.chunks_seen);
                check_field("chunks_expected", want.chunks_expected,
                            out_data.chunks_expected);
                check_field("frame_bytes", want.frame_bytes, out_data.frame_bytes);
                check_field("latency", want.latency, out_data.latency);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int target;
        src_enable = 1'b0;
        done_time  = '0;
        for (int i = 0; i < SLOTS; i++) open_slot(i, '0);
        for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
        for (int i = 0; i < 8; i++) status_tally[i] = 0;
        frame_clock = 48'hFFFF_0000_0000 | 48'($urandom());

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_N; i++) begin
            if (DIRECTED[i].kind == ROW_ENABLE)
                set_enable(DIRECTED[i].enable_val);
            else
                send_chunk(DIRECTED[i].chunk, DIRECTED[i].fixed, DIRECTED[i].want);
        end

        // random bursts under each idle and stall mix
        for (int m = 0; m < NUM_MIXES; m++) begin
            snd_idle  = SND_IDLE[m];
            rcv_stall = RCV_STALL[m];
            if (m == 2) begin
                set_enable(1'b0);
                repeat (12) begin
                    send_chunk(noise_chunk(), 1'b0, NO_RESULT);
                    off_items++;
                end
                set_enable(1'b1);
            end
            target = live_items + ITEMS_PER_MIX;
            while (live_items < target) begin
                send_burst();
                if ($urandom_range(0, 7) == 0) drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d random headers, %0d more with the source off, %0d results checked",
                 live_items, off_items, results_checked);
        $display("complete %0d, late %0d, too many %0d, no slot %0d, evictions %0d",
                 status_tally[ST_COMPLETE], status_tally[ST_LATE],
                 status_tally[ST_TOO_MANY], status_tally[ST_NO_SLOT], evictions);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
